>>> rtl/core/bht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bht_pkg - types and constants of the bucket hash table
// Word types of both channels, status codes and default geometry.
// ----------------------------------------------------------------------------
package bht_pkg;

    localparam int HOME_BUCKETS_DEF     = 16;
    localparam int SLOTS_PER_BUCKET_DEF = 4;
    localparam int OVERFLOW_BUCKETS_DEF = 4;

    localparam int KEY_W = 27;
    localparam int PAY_W = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_HOME     = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_REJECTED = 3'd2,
        ST_FOUND    = 3'd3,
        ST_ABSENT   = 3'd4
    } status_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [4:0]       bucket;
        logic [PAY_W-1:0] found_payload;
        logic [4:0]       overflow_count;
    } out_word_t;

endpackage

`default_nettype wire

>>> rtl/core/bht_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bht_front - input stage and command queue
// Accepts input words, works out the home bucket and queues the command.
// ----------------------------------------------------------------------------
module bht_front
    import bht_pkg::*;
#(
    parameter int HOME_BUCKETS = HOME_BUCKETS_DEF,
    parameter int BW           = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire in_word_t      in_word,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               cmd_valid,
    output in_word_t           cmd_word,
    output logic [BW-1:0]      cmd_home,
    input  wire logic          cmd_take
);

    // key / HOME_BUCKETS by reciprocal multiply; the quotient is low by at most one
    localparam int HL  = $clog2(HOME_BUCKETS);
    localparam int SH  = KEY_W + HL;
    localparam int PRW = SH + KEY_W;
    localparam logic [KEY_W:0]   RECIP = (KEY_W+1)'((64'd1 << SH) / 64'(HOME_BUCKETS));
    localparam logic [KEY_W-1:0] NHB   = KEY_W'(HOME_BUCKETS);

    // two-entry queue
    in_word_t      q_word_reg [2];
    logic [BW-1:0] q_home_reg [2];
    logic          rd_ptr_reg, wr_ptr_reg;
    logic [1:0]    cnt_reg;
    logic [BW-1:0] home;
    logic          push, pop;

    // hash stage
    in_word_t         h_word_reg;
    logic [KEY_W-1:0] h_q_reg;
    logic             h_valid_reg;
    logic             accept;
    logic [PRW-1:0]   prod;
    logic [KEY_W-1:0] qm, r0, r;

    assign prod = PRW'(in_word.key) * PRW'(RECIP);

    always_comb
    begin
        qm   = KEY_W'(h_q_reg * NHB);
        r0   = h_word_reg.key - qm;
        r    = (r0 >= NHB) ? r0 - NHB : r0;
        home = BW'(r);
    end

    assign in_stall  = h_valid_reg && (cnt_reg == 2'd2);
    assign accept    = in_valid && !in_stall;
    assign push      = h_valid_reg && (cnt_reg != 2'd2);
    assign pop       = cmd_take && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_word  = q_word_reg[rd_ptr_reg];
    assign cmd_home  = q_home_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_word_reg <= in_word;
            h_q_reg    <= prod[SH +: KEY_W];
        end
        if (push)
        begin
            q_word_reg[wr_ptr_reg] <= h_word_reg;
            q_home_reg[wr_ptr_reg] <= home;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= 1'b0;
            wr_ptr_reg  <= 1'b0;
            cnt_reg     <= 2'd0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                h_valid_reg <= 1'b1;
            else if (push)
                h_valid_reg <= 1'b0;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bht_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bht_back - table engine
// Executes inserts and bucket-by-bucket lookups against the slot memory.
// ----------------------------------------------------------------------------
module bht_back
    import bht_pkg::*;
#(
    parameter int HOME_BUCKETS     = HOME_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
    parameter int OVERFLOW_BUCKETS = OVERFLOW_BUCKETS_DEF,
    parameter int BW               = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire in_word_t      cmd_word,
    input  wire logic [BW-1:0] cmd_home,
    output logic               cmd_take,
    output logic               out_valid,
    output out_word_t          out_word,
    input  wire logic          out_stall
);

    localparam int TB  = HOME_BUCKETS + OVERFLOW_BUCKETS;
    localparam int OS  = OVERFLOW_BUCKETS * SLOTS_PER_BUCKET;
    localparam int SW  = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int SIW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int OW  = $clog2(OS + 1);
    localparam int KW  = $clog2(OVERFLOW_BUCKETS + 1);
    localparam logic [SW-1:0] SPB = SW'(SLOTS_PER_BUCKET);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // one memory row per bucket, one lane per slot
    logic [KEY_W-1:0] key_mem [TB][SLOTS_PER_BUCKET];
    logic [PAY_W-1:0] pay_mem [TB][SLOTS_PER_BUCKET];
    logic [KEY_W-1:0] rd_key_reg [SLOTS_PER_BUCKET];
    logic [PAY_W-1:0] rd_pay_reg [SLOTS_PER_BUCKET];

    logic [SW-1:0] fill_reg [TB];
    logic [OW-1:0] ovf_reg;
    logic [BW-1:0] ob_ins_reg;

    in_word_t      word_reg;
    logic [BW-1:0] cur_reg;
    logic [KW-1:0] step_reg;
    logic          out_valid_reg;
    out_word_t     out_reg;
    logic [2:0]       res_status_reg;
    logic [4:0]       res_bucket_reg;
    logic [PAY_W-1:0] res_pay_reg;

    logic [BW-1:0] ob_ins;
    logic          hit;
    logic [SIW-1:0] hit_i;

    assign ob_ins = ob_ins_reg;

    always_comb
    begin
        hit   = 1'b0;
        hit_i = '0;
        for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--)
        begin
            if (SW'(i) < fill_reg[cur_reg] && rd_key_reg[i] == word_reg.key)
            begin
                hit   = 1'b1;
                hit_i = SIW'(i);
            end
        end
    end

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            for (int i = 0; i < SLOTS_PER_BUCKET; i++)
            begin
                rd_key_reg[i] <= key_mem[cur_reg][i];
                rd_pay_reg[i] <= pay_mem[cur_reg][i];
            end
        end
        if (cmd_take && cmd_word.kind == KIND_INSERT)
        begin
            if (fill_reg[cmd_home] < SPB)
            begin
                key_mem[cmd_home][fill_reg[cmd_home][SIW-1:0]] <= cmd_word.key;
                pay_mem[cmd_home][fill_reg[cmd_home][SIW-1:0]] <= cmd_word.payload;
            end
            else if (int'(ovf_reg) < OS)
            begin
                key_mem[ob_ins][fill_reg[ob_ins][SIW-1:0]] <= cmd_word.key;
                pay_mem[ob_ins][fill_reg[ob_ins][SIW-1:0]] <= cmd_word.payload;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (cmd_take)
                    state_next = (cmd_word.kind == KIND_INSERT) ? S_OUT : S_READ;
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
                if (hit || fill_reg[cur_reg] != SPB
                    || int'(step_reg) == OVERFLOW_BUCKETS)
                    state_next = S_OUT;
                else
                    state_next = S_READ;
            S_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        priority case (1'b1)
            cmd_take:
            begin
                word_reg <= cmd_word;
                cur_reg  <= cmd_home;
                step_reg <= '0;
                res_pay_reg    <= '0;
                res_bucket_reg <= '0;
                if (cmd_word.kind == KIND_LOOKUP)
                    res_status_reg <= ST_ABSENT;
                else if (fill_reg[cmd_home] < SPB)
                begin
                    res_status_reg <= ST_HOME;
                    res_bucket_reg <= 5'(cmd_home);
                end
                else if (int'(ovf_reg) < OS)
                begin
                    res_status_reg <= ST_OVERFLOW;
                    res_bucket_reg <= 5'(ob_ins);
                end
                else
                    res_status_reg <= ST_REJECTED;
            end
            state_reg == S_CHECK:
            begin
                if (hit)
                begin
                    res_status_reg <= ST_FOUND;
                    res_bucket_reg <= 5'(cur_reg);
                    res_pay_reg    <= rd_pay_reg[hit_i];
                end
                // advance to next overflow bucket
                cur_reg  <= BW'(HOME_BUCKETS + int'(step_reg));
                step_reg <= KW'(int'(step_reg) + 1);
            end
            state_reg == S_OUT:
                if (!out_valid_reg || !out_stall)
                begin
                    out_reg.status         <= res_status_reg;
                    out_reg.bucket         <= res_bucket_reg;
                    out_reg.found_payload  <= res_pay_reg;
                    out_reg.overflow_count <= 5'(ovf_reg);
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ovf_reg       <= '0;
            ob_ins_reg    <= BW'(HOME_BUCKETS);
            for (int b = 0; b < TB; b++)
                fill_reg[b] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cmd_take && cmd_word.kind == KIND_INSERT)
            begin
                if (fill_reg[cmd_home] < SPB)
                    fill_reg[cmd_home] <= fill_reg[cmd_home] + SW'(1);
                else if (int'(ovf_reg) < OS)
                begin
                    fill_reg[ob_ins] <= fill_reg[ob_ins] + SW'(1);
                    ovf_reg          <= ovf_reg + OW'(1);
                    // move on once this overflow bucket is full
                    if (fill_reg[ob_ins] == SPB - SW'(1) && int'(ob_ins) < TB - 1)
                        ob_ins_reg <= ob_ins + BW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bucket_hash_table_with_overflow_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bucket_hash_table_with_overflow_unit - static bucket hash table
// Home buckets plus a sequentially filled shared overflow area.
// ----------------------------------------------------------------------------
//  channel | signals                        | word
//  in      | in_word, in_valid, in_stall    | kind, key, payload
//  out     | out_word, out_valid, out_stall | status, bucket, found_payload,
//          |                                | overflow_count
//
// An accepted word passes the hash stage and the queue; an insert then goes
// to the output register, a lookup reads and checks one row of the slot memory
// per bucket, the home bucket first, then overflow buckets in turn as needed.
// Reset clears the fill counts; slot memory needs no clearing.
// A two-word queue parts the front from the engine; the engine holds a
// finished word in its output register while out_stall is high.
module bucket_hash_table_with_overflow_unit
    import bht_pkg::*;
#(
    parameter int HOME_BUCKETS     = HOME_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
    parameter int OVERFLOW_BUCKETS = OVERFLOW_BUCKETS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_word,
    input  wire logic      in_valid,
    output logic           in_stall,
    output out_word_t      out_word,
    output logic           out_valid,
    input  wire logic      out_stall
);

    localparam int BW = $clog2(HOME_BUCKETS + OVERFLOW_BUCKETS);

    logic          cmd_valid, cmd_take;
    in_word_t      cmd_word;
    logic [BW-1:0] cmd_home;

    bht_front #(.HOME_BUCKETS(HOME_BUCKETS), .BW(BW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .cmd_valid(cmd_valid), .cmd_word(cmd_word),
        .cmd_home(cmd_home), .cmd_take(cmd_take)
    );

    bht_back #(
        .HOME_BUCKETS(HOME_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
        .OVERFLOW_BUCKETS(OVERFLOW_BUCKETS), .BW(BW)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_word(cmd_word),
        .cmd_home(cmd_home), .cmd_take(cmd_take), .out_valid(out_valid),
        .out_word(out_word), .out_stall(out_stall)
    );

endmodule

`default_nettype wire
